// ----- sv/dq_pkg.sv -----
package dq_pkg;

  // Queue geometry.
  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_REAR  = 3'd0,
    REQ_LIST       = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_PUSH_FRONT = 3'd3,
    REQ_POP_REAR   = 3'd4
  } req_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_LIST
  } fsm_state_t;

  // Step forward around the ring.
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Step backward around the ring.
  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// ----- sv/double_ended_queue_top.sv -----
// Bounded double-ended queue of signed 32-bit words held in a ring memory.
// A request is taken at a rising edge where start is high and busy is low;
// req_type selects push rear, push front, pop front, pop rear or list all,
// and push_value carries the word for a push. Unknown request codes are
// taken and dropped without a result.
// Results appear on status, out_value and last_of_run for exactly one cycle
// while valid is high; the receiver cannot stall them.
// A push or pop gives its single result in the cycle after it is taken, and
// a new item may be started in that same cycle, so pushes and pops run at one
// item per cycle. A list of n words gives n results on consecutive cycles,
// the first in the cycle after it is taken; the memory's single read port walks
// one entry per cycle, so busy stays high for all of them but the last, and the
// next item can be started in the cycle of the last result.
// A list or pop on an empty queue, or a push on a full one, gives one result
// with status empty or full and out_value zero.
// Reset (rst, synchronous) empties the queue and drops any list in progress;
// busy is high while rst is high, and the memory contents are not cleared.
module double_ended_queue_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dq_pkg::REQ_W-1:0]          req_type,
  input  logic signed [dq_pkg::DATA_W-1:0]  push_value,
  output logic                              busy,
  output logic                              valid,
  output logic [dq_pkg::STAT_W-1:0]         status,
  output logic signed [dq_pkg::DATA_W-1:0]  out_value,
  output logic                              last_of_run
);
  import dq_pkg::*;

  // Ring memory with a registered read port.
  logic [DATA_W-1:0] store [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;

  // Control state.
  fsm_state_t        state, state_next;
  logic [IDX_W-1:0]  front, front_next;
  logic [IDX_W-1:0]  rear, rear_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  list_ptr, list_ptr_next;
  logic [CNT_W-1:0]  list_left, list_left_next;

  // Result registers.
  logic              res_valid, res_valid_next;
  status_t           stat, stat_next;
  logic              last, last_next;
  logic              from_mem, from_mem_next;

  logic              accept;
  logic              list_more;

  // A list keeps the read port until its last entry has been read.
  assign list_more = (state == S_LIST) && (list_left != CNT_W'(1));
  assign busy      = list_more || rst;
  assign accept    = start && !busy;

  // Next state, memory access and result for this cycle.
  always_comb begin
    state_next     = state;
    front_next     = front;
    rear_next      = rear;
    count_next     = count;
    list_ptr_next  = list_ptr;
    list_left_next = list_left;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = rear;
    rd_addr        = front;
    res_valid_next = 1'b0;
    stat_next      = STAT_OK;
    last_next      = 1'b1;
    from_mem_next  = 1'b0;

    case (state)
      S_LIST: begin
        if (list_more) begin
          // Fetch the next listed word for the following cycle.
          rd_en          = 1'b1;
          rd_addr        = list_ptr;
          list_ptr_next  = ring_next(list_ptr);
          list_left_next = list_left - 1'b1;
          res_valid_next = 1'b1;
          from_mem_next  = 1'b1;
          last_next      = (list_left == CNT_W'(2));
        end else begin
          state_next = S_IDLE;
        end
      end
      default: ;
    endcase

    // A new item is taken whenever no list is still reading.
    if (accept) begin
      case (req_type)
        REQ_PUSH_REAR: begin
          res_valid_next = 1'b1;
          if (count == CNT_W'(DEPTH)) begin
            stat_next = STAT_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = rear;
            rear_next  = ring_next(rear);
            count_next = count + 1'b1;
          end
        end
        REQ_PUSH_FRONT: begin
          res_valid_next = 1'b1;
          if (count == CNT_W'(DEPTH)) begin
            stat_next = STAT_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = ring_prev(front);
            front_next = ring_prev(front);
            count_next = count + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          res_valid_next = 1'b1;
          if (count == '0) begin
            stat_next = STAT_EMPTY;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = front;
            from_mem_next = 1'b1;
            front_next    = ring_next(front);
            count_next    = count - 1'b1;
            if (count == CNT_W'(1)) begin
              front_next = '0;
              rear_next  = '0;
            end
          end
        end
        REQ_POP_REAR: begin
          res_valid_next = 1'b1;
          if (count == '0) begin
            stat_next = STAT_EMPTY;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = ring_prev(rear);
            from_mem_next = 1'b1;
            rear_next     = ring_prev(rear);
            count_next    = count - 1'b1;
            if (count == CNT_W'(1)) begin
              front_next = '0;
              rear_next  = '0;
            end
          end
        end
        REQ_LIST: begin
          if (count == '0) begin
            res_valid_next = 1'b1;
            stat_next      = STAT_EMPTY;
          end else begin
            // First entry is read now; the rest follow one per cycle.
            rd_en          = 1'b1;
            rd_addr        = front;
            list_ptr_next  = ring_next(front);
            list_left_next = count;
            state_next     = S_LIST;
            res_valid_next = 1'b1;
            from_mem_next  = 1'b1;
            last_next      = (count == CNT_W'(1));
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      rear      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      from_mem  <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      rear      <= rear_next;
      count     <= count_next;
      res_valid <= res_valid_next;
      from_mem  <= from_mem_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    list_ptr  <= list_ptr_next;
    list_left <= list_left_next;
    stat      <= stat_next;
    last      <= last_next;
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= DATA_W'(unsigned'(push_value));
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // Result ports.
  assign valid       = res_valid;
  assign status      = stat;
  assign last_of_run = last;
  assign out_value   = from_mem ? signed'(rdata) : '0;

endmodule

// ----- sv/dq_check.sv -----
module dq_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic [dq_pkg::REQ_W-1:0]          req_type,
  input logic                              busy,
  input logic                              valid,
  input logic [dq_pkg::STAT_W-1:0]         status,
  input logic signed [dq_pkg::DATA_W-1:0]  out_value,
  input logic                              last_of_run
);
  import dq_pkg::*;

  // While a list holds the block, every cycle carries one of its results.
  assert property (@(posedge clk) disable iff (rst) busy |-> valid)
    else $error("busy without a result");

  // Every known request gives a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_PUSH_REAR || req_type == REQ_LIST ||
     req_type == REQ_POP_FRONT || req_type == REQ_PUSH_FRONT ||
     req_type == REQ_POP_REAR)) |=> valid)
    else $error("request gave no result");

  // A run that is not finished continues in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (valid && !last_of_run) |=> valid)
    else $error("run of results broke off");

  // Empty and full results stand alone and carry no word.
  assert property (@(posedge clk) disable iff (rst)
    (valid && status != STAT_OK) |-> (out_value == '0 && last_of_run))
    else $error("error result with word or open run");

  // A push reports ok or full and never returns a word.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_PUSH_REAR || req_type == REQ_PUSH_FRONT))
    |=> ((status == STAT_OK || status == STAT_FULL) && out_value == '0 && last_of_run))
    else $error("bad push result");

endmodule

bind double_ended_queue_top dq_check u_dq_check (.*);

// ----- verif/tb_double_ended_queue_top.sv -----
`timescale 1ns / 100ps

module tb_double_ended_queue_top;
  import dq_pkg::*;

  // Request codes past the last defined one are taken and dropped.
  localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_POP_REAR + 1'b1;
  localparam logic [REQ_W-1:0] REQ_LAST_CODE    = '1;

  localparam int ITEM_TARGET   = 420;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    logic [REQ_W-1:0]         code;
    logic signed [DATA_W-1:0] word;
    bit                       wait_drain;
  } deque_req_t;

  typedef struct {
    status_t                  st;
    logic signed [DATA_W-1:0] word;
    logic                     last;
  } deque_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start = 1'b0;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     busy;
  logic                     valid;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] out_value;
  logic                     last_of_run;

  double_ended_queue_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .push_value (push_value),
    .busy       (busy),
    .valid      (valid),
    .status     (status),
    .out_value  (out_value),
    .last_of_run(last_of_run)
  );

  // Items waiting to be driven, and results the deque still owes us.
  deque_req_t    request_backlog[$];
  deque_result_t awaited_results[$];

  // Shadow copy of the deque contents.
  logic signed [DATA_W-1:0] shadow_words[DEPTH];
  int                       shadow_front = 0;
  int                       shadow_rear  = 0;
  int                       shadow_count = 0;

  int unsigned results_predicted = 0;
  int unsigned results_seen      = 0;
  int unsigned fail_count        = 0;
  int unsigned cycle_count       = 0;

  // Stimulus shaping state: occupancy seen by the generator and items counted.
  int gen_count     = 0;
  int counted_items = 0;
  bit drain_next    = 1'b0;

  // Driver state.
  deque_req_t cur_req;
  int         gap_left    = 0;
  int         steady_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void post_result(status_t st, logic signed [DATA_W-1:0] word,
                                      logic last);
    deque_result_t res;
    res.st   = st;
    res.word = word;
    res.last = last;
    awaited_results.push_back(res);
    results_predicted++;
  endfunction

  // Apply one accepted item to the shadow deque and queue what it must return.
  function automatic void predict_deque_request(deque_req_t req);
    int idx;
    case (req.code)
      REQ_PUSH_REAR: begin
        if (shadow_count >= DEPTH) begin
          post_result(STAT_FULL, '0, 1'b1);
        end else begin
          shadow_words[shadow_rear] = req.word;
          shadow_rear = (shadow_rear + 1) % DEPTH;
          shadow_count++;
          post_result(STAT_OK, '0, 1'b1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          post_result(STAT_FULL, '0, 1'b1);
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_words[shadow_front] = req.word;
          shadow_count++;
          post_result(STAT_OK, '0, 1'b1);
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_count == 0) begin
          post_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          post_result(STAT_OK, shadow_words[shadow_front], 1'b1);
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      REQ_POP_REAR: begin
        if (shadow_count == 0) begin
          post_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          shadow_rear = (shadow_rear + DEPTH - 1) % DEPTH;
          post_result(STAT_OK, shadow_words[shadow_rear], 1'b1);
          shadow_count--;
        end
      end
      REQ_LIST: begin
        if (shadow_count == 0) begin
          post_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          idx = shadow_front;
          for (int n = 0; n < shadow_count; n++) begin
            post_result(STAT_OK, shadow_words[idx], n == shadow_count - 1);
            idx = (idx + 1) % DEPTH;
          end
        end
      end
      default: begin
        // Unused codes leave the deque untouched and return nothing.
      end
    endcase
    // Emptying the deque returns both ends to slot zero.
    if (shadow_count == 0) begin
      shadow_front = 0;
      shadow_rear  = 0;
    end
  endfunction

  // Mostly random words, with the sign extremes and zero mixed in.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Idle time before the next item: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_request(logic [REQ_W-1:0] code, logic signed [DATA_W-1:0] word);
    deque_req_t req;
    req.code       = code;
    req.word       = word;
    req.wait_drain = drain_next;
    drain_next     = 1'b0;
    request_backlog.push_back(req);
    case (code)
      REQ_PUSH_REAR, REQ_PUSH_FRONT: if (gen_count < DEPTH) gen_count++;
      REQ_POP_FRONT, REQ_POP_REAR:   if (gen_count > 0) gen_count--;
      default: ;
    endcase
    if (code < REQ_FIRST_UNUSED) counted_items++;
  endtask

  task automatic add_push();
    add_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR, pick_word());
  endtask

  task automatic add_pop();
    add_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR, pick_word());
  endtask

  // Driver: holds an item until the deque takes it, then idles or loads the next.
  always @(posedge clk) begin : drive_proc
    bit line_free;
    bit drained;
    if (rst) begin
      start <= 1'b0;
    end else begin
      drained = results_predicted == results_seen + (valid ? 1 : 0);
      if (start && !busy) begin
        predict_deque_request(cur_req);
        drained = 1'b0;
      end
      line_free = !start || !busy;
      if (line_free) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     (!request_backlog[0].wait_drain || drained)) begin
          cur_req = request_backlog.pop_front();
          start      <= 1'b1;
          req_type   <= cur_req.code;
          push_value <= cur_req.word;
          if (steady_left > 0) begin
            steady_left--;
            gap_left = 0;
          end else begin
            gap_left = pick_gap();
            if ($urandom_range(0, 19) == 0) steady_left = $urandom_range(15, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest outstanding one.
  always @(posedge clk) begin : check_proc
    deque_result_t exp;
    if (!rst && valid) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d, out_value %0d, last_of_run %0b",
               status, out_value, last_of_run);
        fail_count++;
      end else begin
        exp = awaited_results.pop_front();
        if (status !== exp.st) begin
          $error("status: expected %0d, actual %0d", exp.st, status);
          fail_count++;
        end
        if (out_value !== exp.word) begin
          $error("out_value: expected %0d, actual %0d", exp.word, out_value);
          fail_count++;
        end
        if (last_of_run !== exp.last) begin
          $error("last_of_run: expected %0b, actual %0b", exp.last, last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Build the item list, then wait for everything to come back.
  initial begin : stim_proc
    int  kind;
    int  burst;
    int  r;
    bit  paused;
    paused = 1'b0;

    // Empty-queue requests and the unused codes.
    add_request(REQ_POP_FRONT, 32'sh1234_5678);
    add_request(REQ_POP_REAR, '1);
    add_request(REQ_LIST, '0);
    add_request(REQ_FIRST_UNUSED, 32'sh7fff_ffff);
    add_request(REQ_FIRST_UNUSED + 1'b1, 32'sh8000_0000);
    add_request(REQ_LAST_CODE, '1);
    // Extremes pushed at both ends, listed, then popped from both ends.
    add_request(REQ_PUSH_REAR, 32'sh7fff_ffff);
    add_request(REQ_PUSH_FRONT, 32'sh8000_0000);
    add_request(REQ_PUSH_REAR, '0);
    add_request(REQ_PUSH_FRONT, '1);
    add_request(REQ_LIST, 32'sh5555_5555);
    add_request(REQ_POP_FRONT, '0);
    add_request(REQ_POP_REAR, '0);
    add_request(REQ_POP_REAR, '0);
    // This pop empties the queue, so both ends go back to slot zero.
    add_request(REQ_POP_FRONT, '0);
    add_request(REQ_POP_FRONT, '0);
    // A front push right after the reset of the ends wraps below slot zero.
    add_request(REQ_PUSH_FRONT, 32'sha5a5_a5a5);
    add_request(REQ_LIST, '0);
    add_request(REQ_POP_REAR, '0);
    add_request(REQ_PUSH_REAR, 32'sh5a5a_5a5a);
    add_request(REQ_LIST, '0);
    add_request(REQ_POP_FRONT, '0);

    // Let the directed part drain before the random traffic starts.
    drain_next = 1'b1;
    while (counted_items < ITEM_TARGET) begin
      if (!paused && counted_items > ITEM_TARGET / 2) begin
        drain_next = 1'b1;
        paused     = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // Fill to capacity, push into a full queue, then list it.
        while (gen_count < DEPTH) add_push();
        repeat ($urandom_range(1, 3)) add_push();
        add_request(REQ_LIST, pick_word());
      end else if (kind == 2) begin
        // Drain from random ends, pop once more, then list the empty queue.
        while (gen_count > 0) add_pop();
        add_pop();
        add_request(REQ_LIST, pick_word());
      end else if (kind == 3) begin
        add_request(REQ_LIST, pick_word());
      end else begin
        burst = $urandom_range(4, 16);
        repeat (burst) begin
          r = $urandom_range(0, 99);
          if (r < 45) add_push();
          else if (r < 82) add_pop();
          else if (r < 95) add_request(REQ_LIST, pick_word());
          else add_request(REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE)),
                           pick_word());
        end
      end
    end

    @(posedge clk);
    while (request_backlog.size() != 0 || start) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
